### sv/ehp_pkg.sv
// ehp_pkg: shared types and constants for the ethernet/ip header parser
// no dependencies; imported by every module of the block except ehp_in_stage
package ehp_pkg;

    // parse phase, one-hot
    typedef enum logic [3:0] {
        PH_ETH  = 4'b0001,
        PH_IPV4 = 4'b0010,
        PH_IPV6 = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    // network header kinds
    localparam logic [1:0] L3_NONE = 2'd0;
    localparam logic [1:0] L3_IPV4 = 2'd1;
    localparam logic [1:0] L3_IPV6 = 2'd2;

    // transport header kinds
    localparam logic [1:0] L4_NONE = 2'd0;
    localparam logic [1:0] L4_TCP  = 2'd1;
    localparam logic [1:0] L4_UDP  = 2'd2;

    // ethertypes
    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;

    // protocol numbers
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // byte positions and lengths
    localparam logic [7:0] ETYPE_LAST_POS = 8'd13;
    localparam logic [8:0] IPV4_PROTO_POS = 9'd9;
    localparam logic [8:0] IPV6_NH_POS    = 9'd6;
    localparam logic [7:0] IPV6_HDR_LEN   = 8'd40;
    localparam logic [7:0] POS_MAX        = 8'hff;

    // one parsed result beat
    typedef struct packed {
        logic [1:0] l3_kind;
        logic [7:0] l3_offset;
        logic [1:0] l4_kind;
        logic [7:0] l4_offset;
        logic [2:0] vlan_tags;
        logic       incomplete;
    } t_result;

endpackage

### sv/ehp_in_stage.sv
// ehp_in_stage: input register for one frame byte per beat
// depends on nothing outside this file
module ehp_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_packet_byte,
    input  logic       i_end_of_packet,
    input  logic       i_adv,
    output logic       o_full,
    output logic [7:0] o_byte,
    output logic       o_eop
);

    logic       r_full;
    logic       n_full;
    logic [7:0] r_byte;
    logic       r_eop;
    logic       w_accept;

    // hold off upstream while the held byte cannot move on
    assign o_stall  = r_full && !i_adv;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_full = r_full;
        if (w_accept) begin
            n_full = 1'b1;
        end else if (i_adv) begin
            n_full = 1'b0;
        end
    end

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_packet_byte;
            r_eop  <= i_end_of_packet;
        end
    end

    assign o_full = r_full;
    assign o_byte = r_byte;
    assign o_eop  = r_eop;

endmodule

### sv/ehp_parse.sv
// ehp_parse: per-frame parse state and the result of the final byte
// depends on ehp_pkg
module ehp_parse
    import ehp_pkg::*;
#(
    parameter int MAX_VLAN_TAGS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_eop,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [7:0]  r_pos,      n_pos;
    t_phase      r_phase,    n_phase;
    logic [7:0]  r_shift_lo, n_shift_lo;
    logic [2:0]  r_tags,     n_tags;
    logic [1:0]  r_l3_kind,  n_l3_kind;
    logic [7:0]  r_l3_off,   n_l3_off;
    logic [3:0]  r_ihl,      n_ihl;
    logic [1:0]  r_l4_kind,  n_l4_kind;
    logic [7:0]  r_l4_off,   n_l4_off;
    logic        r_ovf,      n_ovf;

    logic [15:0] w_etype;
    logic [7:0]  w_etype_pos;
    logic [7:0]  w_ipv4_l4;
    logic [8:0]  w_pos_x;
    logic [8:0]  w_l3_x;

    assign w_etype     = {r_shift_lo, i_byte};
    assign w_etype_pos = ETYPE_LAST_POS + {3'b000, r_tags, 2'b00};
    assign w_ipv4_l4   = r_l3_off + {2'b00, r_ihl, 2'b00};
    assign w_pos_x     = {1'b0, r_pos};
    assign w_l3_x      = {1'b0, r_l3_off};

    // next state for one byte
    always_comb begin
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_shift_lo = r_shift_lo;
        n_tags     = r_tags;
        n_l3_kind  = r_l3_kind;
        n_l3_off   = r_l3_off;
        n_ihl      = r_ihl;
        n_l4_kind  = r_l4_kind;
        n_l4_off   = r_l4_off;
        n_ovf      = r_ovf;
        if (i_step) begin
            n_shift_lo = i_byte;
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 8'd1;
            end
            case (r_phase)
                PH_ETH: begin
                    if (r_pos == w_etype_pos) begin
                        if (w_etype == ETYPE_VLAN) begin
                            if (r_tags < 3'(MAX_VLAN_TAGS)) begin
                                n_tags = r_tags + 3'd1;
                            end else begin
                                n_ovf   = 1'b1;
                                n_phase = PH_DONE;
                            end
                        end else if (w_etype == ETYPE_IPV4) begin
                            n_l3_kind = L3_IPV4;
                            n_l3_off  = r_pos + 8'd1;
                            n_phase   = PH_IPV4;
                        end else if (w_etype == ETYPE_IPV6) begin
                            n_l3_kind = L3_IPV6;
                            n_l3_off  = r_pos + 8'd1;
                            n_phase   = PH_IPV6;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_IPV4: begin
                    // ihl nibble from the first network byte
                    if (r_pos == r_l3_off) begin
                        n_ihl = i_byte[3:0];
                    end
                    if (w_pos_x == w_l3_x + IPV4_PROTO_POS) begin
                        if (i_byte == PROTO_TCP) begin
                            n_l4_kind = L4_TCP;
                            n_l4_off  = w_ipv4_l4;
                        end else if (i_byte == PROTO_UDP) begin
                            n_l4_kind = L4_UDP;
                            n_l4_off  = w_ipv4_l4;
                        end
                        n_phase = PH_DONE;
                    end
                end
                PH_IPV6: begin
                    if (w_pos_x == w_l3_x + IPV6_NH_POS) begin
                        if (i_byte == PROTO_TCP) begin
                            n_l4_kind = L4_TCP;
                            n_l4_off  = r_l3_off + IPV6_HDR_LEN;
                        end
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    // result from the updated state of the final byte
    always_comb begin
        o_res.l3_kind    = n_l3_kind;
        o_res.l3_offset  = n_l3_off;
        o_res.l4_kind    = n_l4_kind;
        o_res.l4_offset  = n_l4_off;
        o_res.vlan_tags  = n_tags;
        o_res.incomplete = n_ovf || (n_phase != PH_DONE);
    end

    assign o_res_valid = i_step && i_eop;

    // state registers, cleared at the end of every frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_valid) begin
            r_pos      <= 8'd0;
            r_phase    <= PH_ETH;
            r_shift_lo <= 8'd0;
            r_tags     <= 3'd0;
            r_l3_kind  <= L3_NONE;
            r_l3_off   <= 8'd0;
            r_ihl      <= 4'd0;
            r_l4_kind  <= L4_NONE;
            r_l4_off   <= 8'd0;
            r_ovf      <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_shift_lo <= n_shift_lo;
            r_tags     <= n_tags;
            r_l3_kind  <= n_l3_kind;
            r_l3_off   <= n_l3_off;
            r_ihl      <= n_ihl;
            r_l4_kind  <= n_l4_kind;
            r_l4_off   <= n_l4_off;
            r_ovf      <= n_ovf;
        end
    end

endmodule

### sv/ehp_out_stage.sv
// ehp_out_stage: result register toward the downstream channel
// depends on ehp_pkg
module ehp_out_stage
    import ehp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, loaded only when the register is free or being drained
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### sv/ethernet_ip_header_parser_top.sv
// ethernet_ip_header_parser_top: top level of the ethernet/vlan/ip header parser
// depends on ehp_pkg, ehp_in_stage, ehp_parse, ehp_out_stage
//
// Takes a frame one byte per beat and, on the beat marked end of packet, returns
// one result beat with the network and transport header kinds and offsets, the
// number of 0x8100 tags skipped and an incomplete flag. Bytes that are not last
// give no result. One byte is taken every cycle unless the input stalls; each byte
// passes an input register, combinational parse logic and a result register, which
// holds the final result until downstream takes it. The input only stalls while a
// finished result waits in the result register and the downstream side stalls it.
module ethernet_ip_header_parser_top
    import ehp_pkg::*;
#(
    parameter int MAX_VLAN_TAGS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_packet_byte,
    input  logic       i_end_of_packet,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_l3_kind,
    output logic [7:0] o_l3_offset,
    output logic [1:0] o_l4_kind,
    output logic [7:0] o_l4_offset,
    output logic [2:0] o_vlan_tags,
    output logic       o_incomplete
);

    logic       w_full;
    logic [7:0] w_byte;
    logic       w_eop;
    logic       w_adv;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out;

    // held byte moves on when the result register can take a beat
    assign w_adv = w_full && (!o_valid || !i_stall);

    ehp_in_stage u_in (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_packet_byte   (i_packet_byte),
        .i_end_of_packet (i_end_of_packet),
        .i_adv           (w_adv),
        .o_full          (w_full),
        .o_byte          (w_byte),
        .o_eop           (w_eop)
    );

    ehp_parse #(
        .MAX_VLAN_TAGS (MAX_VLAN_TAGS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_adv),
        .i_byte      (w_byte),
        .i_eop       (w_eop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    ehp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (w_out)
    );

    assign o_l3_kind    = w_out.l3_kind;
    assign o_l3_offset  = w_out.l3_offset;
    assign o_l4_kind    = w_out.l4_kind;
    assign o_l4_offset  = w_out.l4_offset;
    assign o_vlan_tags  = w_out.vlan_tags;
    assign o_incomplete = w_out.incomplete;

endmodule

### sv/ehp_checker.sv
// ehp_checker: port-level assertions for the header parser, bound to the top level
// depends on ehp_pkg and ethernet_ip_header_parser_top
module ehp_checker
    import ehp_pkg::*;
#(
    parameter int MAX_VLAN_TAGS = 4
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_packet_byte,
    input logic       i_end_of_packet,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_l3_kind,
    input logic [7:0] o_l3_offset,
    input logic [1:0] o_l4_kind,
    input logic [7:0] o_l4_offset,
    input logic [2:0] o_vlan_tags,
    input logic       o_incomplete
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_l3_kind) && $stable(o_l3_offset)
            && $stable(o_l4_kind) && $stable(o_l4_offset) && $stable(o_vlan_tags)
            && $stable(o_incomplete))
        else $error("result beat changed while stalled");

    // a transport header needs a network header and a finished parse
    a_l4_needs_l3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_l4_kind != L4_NONE) |-> (o_l3_kind != L3_NONE) && !o_incomplete)
        else $error("transport found without network header or with incomplete set");

    // udp is only reported behind ipv4
    a_udp_ipv4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_l4_kind == L4_UDP) |-> (o_l3_kind == L3_IPV4))
        else $error("udp reported without ipv4");

    // no network header means zero offsets
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_l3_kind == L3_NONE) |-> (o_l3_offset == 8'd0) && (o_l4_offset == 8'd0))
        else $error("offset reported without a network header");

    // tag count stays within the limit
    a_tag_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_vlan_tags <= 3'(MAX_VLAN_TAGS)))
        else $error("vlan tag count above limit");

endmodule

bind ethernet_ip_header_parser_top ehp_checker #(
    .MAX_VLAN_TAGS (MAX_VLAN_TAGS)
) u_ehp_checker (.*);
